FILE: rtl/vcd_pkg.sv
package vcd_pkg;

  // Product table size and the index width that follows from it.
  localparam int NUM_PRODUCTS = 16;
  localparam int IDX_W        = (NUM_PRODUCTS > 1) ? $clog2(NUM_PRODUCTS) : 1;

  // Coin stock store: one entry per coin kind.
  localparam int COIN_DEPTH = 3;
  localparam int COIN_AW    = 2;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_BITS  = 72;
  localparam int OUT_BITS = 64;

  // Command codes.
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_UPDATE = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_REFILL = 3'd3;
  localparam logic [2:0] CMD_BUY    = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_SHORT    = 3'd4;
  localparam logic [2:0] ST_NOCHANGE = 3'd5;
  localparam logic [2:0] ST_BADCOIN  = 3'd6;

  // Coin kinds, largest value first.
  localparam logic [1:0] COIN_TEN  = 2'd0;
  localparam logic [1:0] COIN_FIVE = 2'd1;
  localparam logic [1:0] COIN_ONE  = 2'd2;
  localparam logic [1:0] COIN_BAD  = 2'd3;

  // Reciprocal of five scaled by 2^18; shifted one further it gives a tenth.
  // Both quotients are exact for every 16-bit dividend.
  localparam logic [15:0] RECIP_FIVE = 16'hCCCD;
  localparam int          FIVE_SHIFT = 18;
  localparam int          TEN_SHIFT  = 19;

  // Value of n coins of the given kind, built from shifts and adds.
  function automatic logic [15:0] coin_amount(input logic [15:0] n, input logic [1:0] kind);
    logic [15:0] amt;
    case (kind)
      COIN_TEN:  amt = (n << 3) + (n << 1);
      COIN_FIVE: amt = (n << 2) + n;
      default:   amt = n;
    endcase
    return amt;
  endfunction

endpackage

FILE: rtl/vcd_ram.sv
module vcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port; read data is registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/vcd_quot.sv
module vcd_quot
  import vcd_pkg::*;
(
  input  logic        clk,
  input  logic [15:0] rem,
  input  logic [1:0]  kind,
  output logic [15:0] quot
);

  logic [31:0] prod;

  // Division by the coin value through a reciprocal multiply.
  assign prod = 32'(rem) * 32'(RECIP_FIVE);

  // The quotient is registered, ready in the cycle after the remainder.
  always_ff @(posedge clk) begin
    case (kind)
      COIN_TEN:  quot <= 16'(prod >> TEN_SHIFT);
      COIN_FIVE: quot <= 16'(prod >> FIVE_SHIFT);
      default:   quot <= rem;
    endcase
  end

endmodule

FILE: rtl/vending_change_dispenser_core.sv
// Channel | Dir | Transfer when      | Payload
// s_*     | in  | s_tvalid & s_tready | command, product code, price, money, coin kind/count
// m_*     | out | m_tvalid & m_tready | status, change due, tens, fives, ones given
//
// One command is processed at a time. Table commands scan every product slot
// through the table memory, one slot per cycle.
// A successful buy then reads the coin stock, splits the change greedily and
// writes the reduced stock back to the coin memory; a buy whose change cannot be
// paid skips the write-back, and a refill writes back the saturated stock sum.
// Reset clears slot and coin valid bits, so both memories need no clearing pass.
// A stalled result holds the block until the output register is free.
module vending_change_dispenser_core
  import vcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // command[2:0], product_code[18:3], price[34:19], money[50:35],
  // coin_kind[52:51], coin_count[68:53], zero fill above
  input  logic [IN_BITS-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // status[2:0], change_due[18:3], tens_given[31:19], fives_given[45:32],
  // ones_given[61:46], zero fill above
  output logic [OUT_BITS-1:0] m_tdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_CHG_RD, S_CHG_STEP, S_CHG_CHECK,
    S_COMMIT, S_REF_RD, S_REF_WR, S_RESP
  } state_t;

  state_t state;

  // Latched command fields.
  logic [2:0]  cmd;
  logic [15:0] in_code;
  logic [15:0] in_price;
  logic [15:0] in_money;
  logic [1:0]  in_kind;
  logic [15:0] in_count;

  // Table scan.
  logic [NUM_PRODUCTS-1:0] slot_valid;
  logic [IDX_W-1:0]        scan_idx;
  logic                    scan_more;
  logic [IDX_W-1:0]        cmp_idx;
  logic                    cmp_valid;
  logic                    hit_found;
  logic [IDX_W-1:0]        hit_idx;
  logic [15:0]             hit_price;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;

  // Change split.
  logic [COIN_DEPTH-1:0] coin_valid;
  logic [1:0]            coin_k;
  logic [15:0]           rem;
  logic [15:0]           given [COIN_DEPTH];
  logic [15:0]           left  [COIN_DEPTH];

  // Result being built.
  logic [2:0]  res_status;
  logic [15:0] res_due;

  // Memory ports.
  logic                  tbl_we;
  logic [IDX_W-1:0]      tbl_waddr;
  logic [31:0]           tbl_rdata;
  logic                  coin_we;
  logic [COIN_AW-1:0]    coin_waddr;
  logic [15:0]           coin_wdata;
  logic [COIN_AW-1:0]    coin_raddr;
  logic [15:0]           coin_rdata;

  logic [15:0] quot;
  logic [1:0]  have_sel;
  logic [15:0] have;
  logic [15:0] gv;
  logic [16:0] refill_sum;
  logic [15:0] refill_val;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PRODUCTS - 1);

  assign s_tready = (state == S_IDLE);

  // Product table: code in the low half, price in the high half.
  vcd_ram #(.WIDTH(32), .DEPTH(NUM_PRODUCTS), .AW(IDX_W)) u_tbl (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data ({in_price, in_code}),
    .rd_addr (scan_idx),
    .rd_data (tbl_rdata)
  );

  // Coin stock, one entry per kind.
  vcd_ram #(.WIDTH(16), .DEPTH(COIN_DEPTH), .AW(COIN_AW)) u_coin (
    .clk     (clk),
    .wr_en   (coin_we),
    .wr_addr (coin_waddr),
    .wr_data (coin_wdata),
    .rd_addr (coin_raddr),
    .rd_data (coin_rdata)
  );

  vcd_quot u_quot (
    .clk  (clk),
    .rem  (rem),
    .kind (coin_k),
    .quot (quot)
  );

  // Table write on add into a free slot or on a price update.
  always_comb begin
    tbl_we = (state == S_DECIDE) &&
             (((cmd == CMD_ADD) && !hit_found && free_found) ||
              ((cmd == CMD_UPDATE) && hit_found));
    tbl_waddr = (cmd == CMD_ADD) ? free_idx : hit_idx;
  end

  // Coin memory access; an entry never written reads as an empty stock.
  always_comb begin
    coin_raddr = (state == S_REF_RD) ? in_kind : coin_k;
    have_sel   = (state == S_REF_WR) ? in_kind : coin_k;
    have       = coin_valid[have_sel] ? coin_rdata : 16'd0;
    gv         = (quot < have) ? quot : have;
    refill_sum = {1'b0, have} + {1'b0, in_count};
    refill_val = refill_sum[16] ? 16'hFFFF : refill_sum[15:0];
    coin_we    = (state == S_REF_WR) || (state == S_COMMIT);
    coin_waddr = (state == S_REF_WR) ? in_kind : coin_k;
    coin_wdata = (state == S_REF_WR) ? refill_val : left[coin_k];
  end

  // Sequencer with its registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      coin_valid <= '0;
      m_tvalid   <= 1'b0;
      scan_more  <= 1'b0;
      cmp_valid  <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one replaces it.
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      if (coin_we) begin
        coin_valid[coin_waddr] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd        <= s_tdata[2:0];
            in_code    <= s_tdata[18:3];
            in_price   <= s_tdata[34:19];
            in_money   <= s_tdata[50:35];
            in_kind    <= s_tdata[52:51];
            in_count   <= s_tdata[68:53];
            res_status <= ST_OK;
            res_due    <= 16'd0;
            for (int k = 0; k < COIN_DEPTH; k++) begin
              given[k] <= 16'd0;
            end
            scan_idx   <= '0;
            scan_more  <= 1'b1;
            cmp_valid  <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            case (s_tdata[2:0])
              CMD_ADD, CMD_UPDATE, CMD_DELETE, CMD_BUY: begin
                state <= S_SCAN;
              end
              CMD_REFILL: begin
                if (s_tdata[52:51] == COIN_BAD) begin
                  res_status <= ST_BADCOIN;
                  state      <= S_RESP;
                end else begin
                  state <= S_REF_RD;
                end
              end
              default: begin
                res_status <= ST_NOTFOUND;
                state      <= S_RESP;
              end
            endcase
          end
        end

        // Issue one slot read per cycle and compare the slot read before.
        S_SCAN: begin
          cmp_valid <= scan_more;
          cmp_idx   <= scan_idx;
          if (scan_more) begin
            if (scan_idx == LAST_IDX) begin
              scan_more <= 1'b0;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          if (cmp_valid) begin
            if (slot_valid[cmp_idx] && (tbl_rdata[15:0] == in_code) && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= cmp_idx;
              hit_price <= tbl_rdata[31:16];
            end
            if (!slot_valid[cmp_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
            if (cmp_idx == LAST_IDX) begin
              state <= S_DECIDE;
            end
          end
        end

        S_DECIDE: begin
          state <= S_RESP;
          case (cmd)
            CMD_ADD: begin
              if (hit_found) begin
                res_status <= ST_DUP;
              end else if (!free_found) begin
                res_status <= ST_FULL;
              end else begin
                slot_valid[free_idx] <= 1'b1;
              end
            end
            CMD_UPDATE: begin
              if (!hit_found) begin
                res_status <= ST_NOTFOUND;
              end
            end
            CMD_DELETE: begin
              if (hit_found) begin
                slot_valid[hit_idx] <= 1'b0;
              end else begin
                res_status <= ST_NOTFOUND;
              end
            end
            default: begin
              if (!hit_found) begin
                res_status <= ST_NOTFOUND;
              end else if (in_money < hit_price) begin
                res_status <= ST_SHORT;
              end else begin
                res_due <= in_money - hit_price;
                rem     <= in_money - hit_price;
                coin_k  <= COIN_TEN;
                state   <= S_CHG_RD;
              end
            end
          endcase
        end

        // Stock read and quotient for the current coin kind.
        S_CHG_RD: begin
          state <= S_CHG_STEP;
        end

        // Greedy step: take as many coins as the remainder needs, up to the stock.
        S_CHG_STEP: begin
          given[coin_k] <= gv;
          left[coin_k]  <= have - gv;
          rem           <= rem - coin_amount(gv, coin_k);
          if (coin_k == COIN_ONE) begin
            state <= S_CHG_CHECK;
          end else begin
            coin_k <= coin_k + 1'b1;
            state  <= S_CHG_RD;
          end
        end

        S_CHG_CHECK: begin
          if (rem == 16'd0) begin
            coin_k <= COIN_TEN;
            state  <= S_COMMIT;
          end else begin
            res_status <= ST_NOCHANGE;
            for (int k = 0; k < COIN_DEPTH; k++) begin
              given[k] <= 16'd0;
            end
            state <= S_RESP;
          end
        end

        // Write the reduced stock back, one kind per cycle.
        S_COMMIT: begin
          if (coin_k == COIN_ONE) begin
            state <= S_RESP;
          end else begin
            coin_k <= coin_k + 1'b1;
          end
        end

        S_REF_RD: begin
          state <= S_REF_WR;
        end

        S_REF_WR: begin
          state <= S_RESP;
        end

        // Hand the result to the output register once it is free.
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, given[2], given[1][13:0], given[0][12:0],
                         res_due, res_status};
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb_top.sv
module tb_top
  import vcd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Command codes that the block does not decode.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int COIN_KINDS = 3;
  localparam int COIN_VALUE [COIN_KINDS] = '{10, 5, 1};
  localparam int POOL_SIZE = 24;
  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] code;
    logic [15:0] price;
    logic [15:0] money;
    logic [1:0]  kind;
    logic [15:0] count;
  } vend_cmd_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] due;
    logic [12:0] tens;
    logic [13:0] fives;
    logic [15:0] ones;
  } receipt_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;

  // Shadow copy of the product table and the coin stock.
  logic [15:0] shelf_code  [NUM_PRODUCTS];
  logic [15:0] shelf_price [NUM_PRODUCTS];
  logic        shelf_valid [NUM_PRODUCTS];
  logic [15:0] coin_stock  [COIN_KINDS];

  receipt_t receipts_due [$];
  int       mismatches = 0;
  int       burst_left = 0;
  logic [15:0] code_pool [POOL_SIZE];

  vending_change_dispenser_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic vend_cmd_t mk(logic [2:0] cmd, logic [15:0] code, logic [15:0] price,
                                   logic [15:0] money, logic [1:0] kind, logic [15:0] count);
    vend_cmd_t c;
    c.cmd = cmd;
    c.code = code;
    c.price = price;
    c.money = money;
    c.kind = kind;
    c.count = count;
    return c;
  endfunction

  // First valid slot holding the code, or -1.
  function automatic int find_code(logic [15:0] code);
    for (int i = 0; i < NUM_PRODUCTS; i++) begin
      if (shelf_valid[i] && shelf_code[i] == code) return i;
    end
    return -1;
  endfunction

  // Applies one command to the shadow state and returns the receipt it gives.
  function automatic receipt_t vend_outcome(vend_cmd_t c);
    receipt_t r;
    int slot;
    int free_slot;
    int sum;
    int rem;
    int want;
    int given [COIN_KINDS];
    r = '{status: ST_OK, due: '0, tens: '0, fives: '0, ones: '0};
    slot = find_code(c.code);
    case (c.cmd)
      CMD_ADD: begin
        if (slot >= 0) begin
          r.status = ST_DUP;
        end else begin
          free_slot = -1;
          for (int i = NUM_PRODUCTS - 1; i >= 0; i--) begin
            if (!shelf_valid[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            r.status = ST_FULL;
          end else begin
            shelf_code[free_slot] = c.code;
            shelf_price[free_slot] = c.price;
            shelf_valid[free_slot] = 1'b1;
          end
        end
      end
      CMD_UPDATE: begin
        if (slot < 0) r.status = ST_NOTFOUND;
        else shelf_price[slot] = c.price;
      end
      CMD_DELETE: begin
        if (slot < 0) r.status = ST_NOTFOUND;
        else shelf_valid[slot] = 1'b0;
      end
      CMD_REFILL: begin
        if (c.kind == COIN_BAD) begin
          r.status = ST_BADCOIN;
        end else begin
          sum = int'(coin_stock[c.kind]) + int'(c.count);
          coin_stock[c.kind] = (sum > 65535) ? 16'hFFFF : 16'(sum);
        end
      end
      CMD_BUY: begin
        if (slot < 0) begin
          r.status = ST_NOTFOUND;
        end else if (c.money < shelf_price[slot]) begin
          r.status = ST_SHORT;
        end else begin
          r.due = c.money - shelf_price[slot];
          rem = int'(r.due);
          // Greedy split from the largest coin down, capped by stock.
          for (int k = 0; k < COIN_KINDS; k++) begin
            want = rem / COIN_VALUE[k];
            given[k] = (want < int'(coin_stock[k])) ? want : int'(coin_stock[k]);
            rem -= given[k] * COIN_VALUE[k];
          end
          if (rem == 0) begin
            for (int k = 0; k < COIN_KINDS; k++) coin_stock[k] -= 16'(given[k]);
            r.tens = 13'(given[0]);
            r.fives = 14'(given[1]);
            r.ones = 16'(given[2]);
          end else begin
            r.status = ST_NOCHANGE;
          end
        end
      end
      default: r.status = ST_NOTFOUND;
    endcase
    return r;
  endfunction

  // Sends one command in bursts of random length separated by random gaps.
  task automatic send_command(vend_cmd_t c);
    int gap;
    receipts_due.push_back(vend_outcome(c));
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_BITS - 69){1'b0}}, c.count, c.kind, c.money, c.price, c.code, c.cmd};
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver stalls: long stall-free stretches alternate with random stalls.
  logic [9:0] rx_phase = '0;
  int         rx_stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_phase <= rx_phase + 1'b1;
      if (rx_phase[9:8] == 2'b11) begin
        m_tready <= 1'b1;
      end else if (rx_stall > 0) begin
        m_tready <= 1'b0;
        rx_stall <= rx_stall - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        rx_stall <= $urandom_range(0, 10);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Each result transfer is compared with the oldest outstanding receipt.
  always @(posedge clk) begin : check_results
    receipt_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (receipts_due.size() == 0) begin
        $error("result transfer with no command outstanding: %h", m_tdata);
        mismatches++;
      end else begin
        want = receipts_due.pop_front();
        check_field("status", want.status, m_tdata[2:0]);
        check_field("change_due", want.due, m_tdata[18:3]);
        check_field("tens_given", want.tens, m_tdata[31:19]);
        check_field("fives_given", want.fives, m_tdata[45:32]);
        check_field("ones_given", want.ones, m_tdata[61:46]);
      end
    end
  end

  // Commands against an empty table and undecoded command codes.
  task automatic test_empty_table();
    send_command(mk(CMD_BUY, 16'h1234, 16'h0000, 16'hFFFF, COIN_TEN, 16'h0000));
    send_command(mk(CMD_UPDATE, 16'h0000, 16'h0005, 16'h0000, COIN_TEN, 16'h0000));
    send_command(mk(CMD_DELETE, 16'hFFFF, 16'h0000, 16'h0000, COIN_TEN, 16'h0000));
    send_command(mk(CMD_SPARE_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF, COIN_BAD, 16'hFFFF));
    send_command(mk(CMD_SPARE_LO, 16'h0000, 16'h0000, 16'h0000, COIN_TEN, 16'h0000));
  endtask

  // Refill of every kind, saturation of a count and the invalid coin kind.
  task automatic test_coin_refill();
    send_command(mk(CMD_REFILL, 16'h0000, 16'h0000, 16'h0000, COIN_BAD, 16'hFFFF));
    send_command(mk(CMD_REFILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, COIN_TEN, 16'hFFFF));
    send_command(mk(CMD_REFILL, 16'h0000, 16'h0000, 16'h0000, COIN_TEN, 16'h0001));
    send_command(mk(CMD_REFILL, 16'h0000, 16'h0000, 16'h0000, COIN_FIVE, 16'h0003));
    send_command(mk(CMD_REFILL, 16'h0000, 16'h0000, 16'h0000, COIN_ONE, 16'h0002));
  endtask

  // Adding products at the code and price extremes, and a duplicate add.
  task automatic test_product_admin();
    send_command(mk(CMD_ADD, 16'h0000, 16'h0000, 16'h0000, COIN_TEN, 16'h0000));
    send_command(mk(CMD_ADD, 16'hFFFF, 16'hFFFF, 16'h0000, COIN_TEN, 16'h0000));
    send_command(mk(CMD_ADD, 16'h0000, 16'h0007, 16'h0000, COIN_TEN, 16'h0000));
  endtask

  // Exact money, short money, change that cannot be paid, the largest change and a deleted code.
  task automatic test_buy_cases();
    send_command(mk(CMD_BUY, 16'h0000, 16'h0000, 16'h0000, COIN_TEN, 16'h0000));
    send_command(mk(CMD_BUY, 16'hFFFF, 16'h0000, 16'hFFFE, COIN_TEN, 16'h0000));
    send_command(mk(CMD_BUY, 16'hFFFF, 16'h0000, 16'hFFFF, COIN_TEN, 16'h0000));
    send_command(mk(CMD_UPDATE, 16'h0000, 16'h0001, 16'h0000, COIN_TEN, 16'h0000));
    send_command(mk(CMD_BUY, 16'h0000, 16'h0000, 16'hFFFF, COIN_TEN, 16'h0000));
    send_command(mk(CMD_REFILL, 16'h0000, 16'h0000, 16'h0000, COIN_ONE, 16'h000A));
    send_command(mk(CMD_BUY, 16'h0000, 16'h0000, 16'hFFFF, COIN_TEN, 16'h0000));
    send_command(mk(CMD_BUY, 16'h0000, 16'h0000, 16'h0010, COIN_TEN, 16'h0000));
    send_command(mk(CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, COIN_TEN, 16'h0000));
    send_command(mk(CMD_BUY, 16'h0000, 16'h0000, 16'hFFFF, COIN_TEN, 16'h0000));
  endtask

  // Mostly well-formed traffic on a small pool of codes, so that the table
  // fills up, with some unknown codes and undecoded commands mixed in.
  function automatic vend_cmd_t random_command();
    vend_cmd_t c;
    int pick;
    int slot;
    int p;
    int m;
    c = mk(CMD_BUY, 16'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
           16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 20) c.cmd = CMD_ADD;
    else if (pick < 30) c.cmd = CMD_UPDATE;
    else if (pick < 40) c.cmd = CMD_DELETE;
    else if (pick < 60) c.cmd = CMD_REFILL;
    else if (pick < 95) c.cmd = CMD_BUY;
    else c.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    if ($urandom_range(0, 9) != 0) c.code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
    if ($urandom_range(0, 9) < 7) c.price = 16'($urandom_range(0, 200));
    case (c.cmd)
      CMD_REFILL: begin
        pick = $urandom_range(0, 99);
        if (pick < 90) c.kind = 2'($urandom_range(COIN_TEN, COIN_ONE));
        else c.kind = COIN_BAD;
        pick = $urandom_range(0, 99);
        if (pick < 93) c.count = 16'($urandom_range(0, 25));
        else if (pick < 98) c.count = 16'($urandom);
        else c.count = 16'hFFFF;
      end
      CMD_BUY: begin
        slot = find_code(c.code);
        if (slot >= 0) begin
          p = int'(shelf_price[slot]);
          pick = $urandom_range(0, 99);
          if (pick < 60) m = p + $urandom_range(0, 40);
          else if (pick < 70) m = p;
          else if (pick < 85 && p > 0) m = p - $urandom_range(1, (p < 30) ? p : 30);
          else m = $urandom_range(0, 65535);
          c.money = (m > 65535) ? 16'hFFFF : 16'(m);
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic test_random_traffic();
    code_pool[0] = 16'h0000;
    code_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) code_pool[i] = 16'($urandom);
    for (int n = 0; n < RANDOM_ITEMS; n++) send_command(random_command());
  endtask

  initial begin
    for (int i = 0; i < NUM_PRODUCTS; i++) begin
      shelf_code[i] = '0;
      shelf_price[i] = '0;
      shelf_valid[i] = 1'b0;
    end
    for (int k = 0; k < COIN_KINDS; k++) coin_stock[k] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_coin_refill();
    test_product_admin();
    test_buy_cases();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (receipts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/vcd_pkg.sv
rtl/vcd_ram.sv
rtl/vcd_quot.sv
rtl/vending_change_dispenser_core.sv
tb/tb_top.sv
